FILE: design/ssd_pkg.sv
// Shared types, constants and width helpers for the segment distance block.
package ssd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int FIELD_W        = 16;
  localparam int DIST_W         = 25;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_POINT = 2'd1,
    MODE_FOOT  = 2'd2
  } ssd_mode_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_start_x;
    logic signed [FIELD_W-1:0] a_start_y;
    logic signed [FIELD_W-1:0] a_end_x;
    logic signed [FIELD_W-1:0] a_end_y;
    logic signed [FIELD_W-1:0] b_start_x;
    logic signed [FIELD_W-1:0] b_start_y;
    logic signed [FIELD_W-1:0] b_end_x;
    logic signed [FIELD_W-1:0] b_end_y;
  } ssd_in_t;

  typedef struct packed {
    logic              intersects;
    logic [DIST_W-1:0] distance;
  } ssd_out_t;

  function automatic int in_bits(int cb);
    return (cb < FIELD_W) ? cb : FIELD_W;
  endfunction

  // one job: mode, point distance squared, cross magnitude, length squared
  function automatic int job_w(int cb);
    return 2 + 3 * (2 * in_bits(cb) + 1);
  endfunction

  function automatic int queue_w(int cb);
    return 1 + 4 * job_w(cb);
  endfunction

endpackage

FILE: design/ssd_front.sv
// Front end: coordinate differences, cross/dot products and classification.
module ssd_front #(
  parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF,
  localparam int QW = ssd_pkg::queue_w(COORD_BITS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  ssd_pkg::ssd_in_t item,
  input  logic            q_full,
  output logic            q_push,
  output logic [QW-1:0]   q_data
);
  import ssd_pkg::*;

  localparam int N   = in_bits(COORD_BITS);
  localparam int DW  = N + 1;
  localparam int XW  = 2 * DW;
  localparam int SQW = 2 * N + 1;
  localparam int JW  = job_w(COORD_BITS);

  function automatic logic signed [DW-1:0] dec(logic [FIELD_W-1:0] f);
    logic [N-1:0] v;
    v = f[N-1:0];
    return {v[N-1], v};
  endfunction

  logic en;
  logic v1, v2, v3;

  logic signed [DW-1:0] sx [4];
  logic signed [DW-1:0] sy [4];
  logic signed [DW-1:0] ex [4];
  logic signed [DW-1:0] ey [4];
  logic signed [DW-1:0] px [4];
  logic signed [DW-1:0] py [4];

  logic signed [DW-1:0] lx [4];
  logic signed [DW-1:0] ly [4];
  logic signed [DW-1:0] qx [4];
  logic signed [DW-1:0] qy [4];
  logic signed [DW-1:0] fx [4];
  logic signed [DW-1:0] fy [4];

  logic signed [XW-1:0] m_lxqy [4];
  logic signed [XW-1:0] m_lyqx [4];
  logic signed [XW-1:0] m_lxqx [4];
  logic signed [XW-1:0] m_lyqy [4];
  logic signed [XW-1:0] m_lxlx [4];
  logic signed [XW-1:0] m_lyly [4];
  logic signed [XW-1:0] m_qxqx [4];
  logic signed [XW-1:0] m_qyqy [4];
  logic signed [XW-1:0] m_fxfx [4];
  logic signed [XW-1:0] m_fyfy [4];

  logic signed [XW-1:0] cr   [4];
  logic signed [XW-1:0] dt   [4];
  logic signed [XW-1:0] len2 [4];
  logic signed [XW-1:0] qq   [4];
  logic signed [XW-1:0] ee   [4];

  logic [3:0] z, ng, on;
  logic [1:0] mode [4];
  logic [SQW-1:0] pt [4];
  logic [SQW-1:0] cm [4];
  logic signed [XW-1:0] crn [4];
  logic z12, z34, n12, n34, p12, p34, hit;

  assign en         = !(v3 && q_full);
  assign item_stall = !en;
  assign q_push     = v3 && !q_full;

  // job 0/1: points of B against A, job 2/3: points of A against B
  always_comb begin
    sx[0] = dec(item.a_start_x); sy[0] = dec(item.a_start_y);
    ex[0] = dec(item.a_end_x);   ey[0] = dec(item.a_end_y);
    sx[1] = sx[0]; sy[1] = sy[0]; ex[1] = ex[0]; ey[1] = ey[0];
    sx[2] = dec(item.b_start_x); sy[2] = dec(item.b_start_y);
    ex[2] = dec(item.b_end_x);   ey[2] = dec(item.b_end_y);
    sx[3] = sx[2]; sy[3] = sy[2]; ex[3] = ex[2]; ey[3] = ey[2];
    px[0] = sx[2]; py[0] = sy[2];
    px[1] = ex[2]; py[1] = ey[2];
    px[2] = sx[0]; py[2] = sy[0];
    px[3] = ex[0]; py[3] = ey[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        lx[j] <= ex[j] - sx[j];
        ly[j] <= ey[j] - sy[j];
        qx[j] <= px[j] - sx[j];
        qy[j] <= py[j] - sy[j];
        fx[j] <= px[j] - ex[j];
        fy[j] <= py[j] - ey[j];

        m_lxqy[j] <= lx[j] * qy[j];
        m_lyqx[j] <= ly[j] * qx[j];
        m_lxqx[j] <= lx[j] * qx[j];
        m_lyqy[j] <= ly[j] * qy[j];
        m_lxlx[j] <= lx[j] * lx[j];
        m_lyly[j] <= ly[j] * ly[j];
        m_qxqx[j] <= qx[j] * qx[j];
        m_qyqy[j] <= qy[j] * qy[j];
        m_fxfx[j] <= fx[j] * fx[j];
        m_fyfy[j] <= fy[j] * fy[j];

        cr[j]   <= m_lxqy[j] - m_lyqx[j];
        dt[j]   <= m_lxqx[j] + m_lyqy[j];
        len2[j] <= m_lxlx[j] + m_lyly[j];
        qq[j]   <= m_qxqx[j] + m_qyqy[j];
        ee[j]   <= m_fxfx[j] + m_fyfy[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      z[j]   = (cr[j] == 0);
      ng[j]  = cr[j][XW-1];
      on[j]  = (qq[j] == 0) || (z[j] && (dt[j] > 0) && (qq[j] <= len2[j]));
      crn[j] = ng[j] ? -cr[j] : cr[j];
      cm[j]  = crn[j][SQW-1:0];
      if (on[j]) begin
        mode[j] = MODE_ZERO;
        pt[j]   = qq[j][SQW-1:0];
      end else if (dt[j] < 0 || len2[j] == 0) begin
        mode[j] = MODE_POINT;
        pt[j]   = qq[j][SQW-1:0];
      end else if (len2[j] > dt[j]) begin
        mode[j] = MODE_FOOT;
        pt[j]   = qq[j][SQW-1:0];
      end else begin
        mode[j] = MODE_POINT;
        pt[j]   = ee[j][SQW-1:0];
      end
    end
    z12 = z[0] || z[1];
    z34 = z[2] || z[3];
    n12 = !z12 && (ng[0] != ng[1]);
    n34 = !z34 && (ng[2] != ng[3]);
    p12 = !z12 && (ng[0] == ng[1]);
    p34 = !z34 && (ng[2] == ng[3]);
    if (z12 && z34)
      hit = |on;
    else
      hit = (n12 && !p34) || (!p12 && n34);
    q_data[QW-1] = hit;
    for (int j = 0; j < 4; j++)
      q_data[j*JW +: JW] = {mode[j], pt[j], cm[j], len2[j][SQW-1:0]};
  end

endmodule

FILE: design/ssd_queue.sv
// Small register queue between front and back ends.
module ssd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ssd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);
  import ssd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr] <= push_data;
  end

endmodule

FILE: design/ssd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ssd_div #(
  parameter int DEN_W = 33,
  parameter int QUO_W = 49,
  localparam int NUM_W = DEN_W + QUO_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);
  import ssd_pkg::*;

  logic [DEN_W-1:0] rem   [QUO_W+1];
  logic [QUO_W-1:0] lo    [QUO_W+1];
  logic [QUO_W-1:0] qb    [QUO_W+1];
  logic [DEN_W-1:0] den_p [QUO_W+1];

  assign rem[0]   = num[NUM_W-1:QUO_W];
  assign lo[0]    = num[QUO_W-1:0];
  assign qb[0]    = '0;
  assign den_p[0] = den;
  assign quo      = qb[QUO_W];

  for (genvar t = 0; t < QUO_W; t++) begin : g_stage
    logic [DEN_W:0] rt, df;
    logic           ge;
    always_comb begin
      rt = {rem[t], lo[t][QUO_W-1]};
      df = rt - {1'b0, den_p[t]};
      ge = (rt >= {1'b0, den_p[t]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[t+1]   <= ge ? df[DEN_W-1:0] : rt[DEN_W-1:0];
        lo[t+1]    <= lo[t] << 1;
        qb[t+1]    <= {qb[t][QUO_W-2:0], ge};
        den_p[t+1] <= den_p[t];
      end
    end
  end

endmodule

FILE: design/ssd_back.sv
// Back end: foot distances by division, minimum, square root, result register.
module ssd_back #(
  parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssd_pkg::FRAC_BITS_DEF,
  localparam int QW = ssd_pkg::queue_w(COORD_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic [QW-1:0]     q_head,
  output logic              result_valid,
  input  logic              result_stall,
  output ssd_pkg::ssd_out_t result
);
  import ssd_pkg::*;

  localparam int N   = in_bits(COORD_BITS);
  localparam int SQW = 2 * N + 1;
  localparam int JW  = job_w(COORD_BITS);
  localparam int DSW = SQW + 2 * FRAC_BITS;
  localparam int NW  = SQW + DSW;
  localparam int RW  = (DSW + 1) / 2;
  localparam int MW  = (RW > DIST_W) ? RW : DIST_W;
  localparam int SW  = 1 + 4 * (2 + DSW);

  logic en;
  logic v0, v1, vm1, vm2;
  logic [DSW:0] dv;
  logic [RW:0]  sv;

  logic [QW-1:0]    b0;
  logic [1:0]       md0 [4];
  logic [SQW-1:0]   pt0 [4];
  logic [SQW-1:0]   cm0 [4];
  logic [SQW-1:0]   ln0 [4];

  logic [2*SQW-1:0] csq1 [4];
  logic [SQW-1:0]   ln1  [4];
  logic [DSW-1:0]   ptq1 [4];
  logic [1:0]       md1  [4];
  logic             hit1;

  logic [SW-1:0]    side [DSW+1];
  logic [DSW-1:0]   quo  [4];
  logic [DSW-1:0]   dsq  [4];

  logic [DSW-1:0]   m01, m23, mm;
  logic             hm1, hm2;

  logic [RW+1:0]    rem  [RW+1];
  logic [RW-1:0]    root [RW+1];
  logic [2*RW-1:0]  xs   [RW+1];
  logic             hs   [RW+1];

  logic [MW-1:0]     rootx;
  logic [DIST_W-1:0] satv;

  assign en    = !(result_valid && result_stall);
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      dv[DSW:1]    <= '0;
      vm1          <= 1'b0;
      vm2          <= 1'b0;
      sv[RW:1]     <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      v0           <= q_pop;
      v1           <= v0;
      dv[DSW:1]    <= dv[DSW-1:0];
      vm1          <= dv[DSW];
      vm2          <= vm1;
      sv[RW:1]     <= sv[RW-1:0];
      result_valid <= sv[RW];
    end
  end

  assign dv[0] = v1;
  assign sv[0] = vm2;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ln0[j] = b0[j*JW +: SQW];
      cm0[j] = b0[j*JW + SQW +: SQW];
      pt0[j] = b0[j*JW + 2*SQW +: SQW];
      md0[j] = b0[j*JW + 3*SQW +: 2];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)
      b0 <= q_head;
    if (en) begin
      hit1 <= b0[QW-1];
      for (int j = 0; j < 4; j++) begin
        csq1[j] <= cm0[j] * cm0[j];
        ln1[j]  <= ln0[j];
        ptq1[j] <= DSW'(pt0[j]) << (2 * FRAC_BITS);
        md1[j]  <= md0[j];
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_div
    ssd_div #(
      .DEN_W (SQW),
      .QUO_W (DSW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (NW'(csq1[j]) << (2 * FRAC_BITS)),
      .den (ln1[j]),
      .quo (quo[j])
    );
    assign side[0][j*(2+DSW) +: 2+DSW] = {md1[j], ptq1[j]};
  end
  assign side[0][SW-1] = hit1;

  for (genvar t = 0; t < DSW; t++) begin : g_side
    always_ff @(posedge clk) begin
      if (en)
        side[t+1] <= side[t];
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      case (side[DSW][j*(2+DSW) + DSW +: 2])
        MODE_ZERO:  dsq[j] = '0;
        MODE_FOOT:  dsq[j] = quo[j];
        default:    dsq[j] = side[DSW][j*(2+DSW) +: DSW];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m01 <= (dsq[1] < dsq[0]) ? dsq[1] : dsq[0];
      m23 <= (dsq[3] < dsq[2]) ? dsq[3] : dsq[2];
      hm1 <= side[DSW][SW-1];
      mm  <= (m23 < m01) ? m23 : m01;
      hm2 <= hm1;
    end
  end

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = (2*RW)'(mm);
  assign hs[0]   = hm2;

  for (genvar t = 0; t < RW; t++) begin : g_sqrt
    logic [RW+3:0] rt, trial, df;
    logic          ge;
    always_comb begin
      rt    = {rem[t], xs[t][2*RW-1 -: 2]};
      trial = (RW+4)'({root[t], 2'b01});
      df    = rt - trial;
      ge    = (rt >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[t+1]  <= ge ? df[RW+1:0] : rt[RW+1:0];
        root[t+1] <= (RW > 1) ? {root[t][RW-2:0], ge} : RW'(ge);
        xs[t+1]   <= xs[t] << 2;
        hs[t+1]   <= hs[t];
      end
    end
  end

  always_comb begin
    rootx = MW'(root[RW]);
    satv  = (rootx > MW'(DIST_MAX)) ? DIST_MAX : rootx[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.intersects <= hs[RW];
      result.distance   <= hs[RW] ? '0 : satv;
    end
  end

endmodule

FILE: design/segment_segment_distance.sv
// Top level of the 2D segment-to-segment distance block.
// Input channel item/item_valid/item_stall carries one segment pair per beat;
// output channel result/result_valid/result_stall returns one beat per pair
// with the intersect flag and the floored distance in Q.8 fixed point.
// A beat is taken at a clock edge where valid is high and stall is low.
// Throughput is one pair per cycle while no stall holds. A pair passes 3
// front stages, the queue, 2 back stages, 2*N+1+2*FRAC_BITS divider stages,
// 2 minimum stages, ceil((2*N+1+2*FRAC_BITS)/2) root stages and the result
// register, N being the coordinate width up to 16.
// The front end feeds a four-entry queue; when the queue fills it raises
// item_stall. When result_stall holds a waiting result, the back pipeline
// freezes while the front keeps accepting until the queue is full.
// Synchronous reset empties the pipelines and the queue; no pass is needed.
module segment_segment_distance #(
  parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssd_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ssd_pkg::ssd_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output ssd_pkg::ssd_out_t result
);
  import ssd_pkg::*;

  localparam int QW = queue_w(COORD_BITS);

  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_data, q_head;

  ssd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  ssd_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ssd_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_head       (q_head),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.intersects |-> result.distance == '0)
    else $error("intersecting pair with nonzero distance");

endmodule
